/* rtl/min_mismatch_candidate_select_macros.svh */
// Assertion helpers for the checker file.
`ifndef MIN_MISMATCH_CANDIDATE_SELECT_MACROS_SVH
`define MIN_MISMATCH_CANDIDATE_SELECT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define MMCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define MMCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mmcs_pkg.sv */
package mmcs_pkg;

    localparam int MAX_LETTERS      = 64;
    localparam int WEIGHT_FRAC_BITS = 16;

    localparam int LEN_W   = 7;
    localparam int POS_W   = 7;
    localparam int LTR_W   = 8;
    localparam int ID_W    = 6;
    localparam int ERR_W   = 7;
    localparam int SCORE_W = 25;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(40);

    // tdata layout on the result side: id, errors, score, zero fill to bytes
    localparam int OUT_ERR_LSB   = ID_W;
    localparam int OUT_SCORE_LSB = ID_W + ERR_W;
    localparam int OUT_BITS      = ID_W + ERR_W + SCORE_W;
    localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

    // tdata layout on the letter side: cand letter, ref letter, id
    localparam int IN_BITS   = 2 * LTR_W + ID_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [LTR_W-1:0] cand_letter;
        logic [LTR_W-1:0] ref_letter;
        logic [ID_W-1:0]  cand_id;
        logic             last_letter;
        logic             last_cand;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0]    best_id;
        logic [ERR_W-1:0]   best_errors;
        logic [SCORE_W-1:0] best_score;
    } t_result;

    typedef logic [SCORE_W-1:0] t_wtab [0:MAX_LETTERS];

    // Entry n is ln(n) scaled by 2^WEIGHT_FRAC_BITS, rounded half up.
    function automatic t_wtab f_wtab();
        t_wtab tab;
        real   v;
        tab[0] = '0;
        for (int n = 1; n <= MAX_LETTERS; n++) begin
            v      = $ln(real'(n)) * (2.0 ** WEIGHT_FRAC_BITS);
            tab[n] = SCORE_W'($rtoi(v + 0.5));
        end
        return tab;
    endfunction

    localparam t_wtab W_TAB = f_wtab();

endpackage

/* rtl/min_mismatch_candidate_select.sv */
// Flow: an accepted letter is held in the input register stage and is scored when it
//   leaves that stage; a winner it closes is loaded into the result register at that
//   point and offered on the result port from there.
// Throughput: one letter per cycle; the scoring register stage takes one letter each
//   cycle and stalls only when a set ends while the result register is still full and
//   its transfer does not happen in that cycle.
// Reset (i_rst_n low, synchronous): drop all in-flight transfers, clear the running
//   candidate and the held winner, and set string_length to 40.
module min_mismatch_candidate_select import mmcs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // letter side
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [7:0] cand_letter, [15:8] ref_letter, [21:16] cand_id, [23:22] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                  i_s_axis_tlast,   // last_letter
    input  logic [0:0]            i_s_axis_tuser,   // [0] last_cand
    // result side
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [5:0] best_id, [12:6] best_errors, [37:13] best_score, [39:38] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // configuration: string_length
    input  logic                  i_cfg_we,
    input  logic [LEN_W-1:0]      i_cfg_wdata
);

    logic [LEN_W-1:0] r_len;

    // Input register stage.
    logic  r_s1_valid;
    t_item r_s1_item;

    // Result register.
    logic    r_out_valid;
    t_result r_out;

    logic    in_fire;
    logic    s1_emits;
    logic    s1_fire;
    logic    out_free;
    t_item   in_item;
    t_result track_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_wdata;
        end
    end

    assign in_item.cand_letter = i_s_axis_tdata[LTR_W-1:0];
    assign in_item.ref_letter  = i_s_axis_tdata[2*LTR_W-1:LTR_W];
    assign in_item.cand_id     = i_s_axis_tdata[IN_BITS-1:2*LTR_W];
    assign in_item.last_letter = i_s_axis_tlast;
    assign in_item.last_cand   = i_s_axis_tuser[0];

    // A letter closing a set needs a free result slot; any other letter
    // advances regardless of the result side.
    assign s1_emits = r_s1_item.last_letter & r_s1_item.last_cand;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign s1_fire  = r_s1_valid && (!s1_emits || out_free);

    assign o_s_axis_tready = !r_s1_valid || s1_fire;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_fire || (r_s1_valid && !s1_fire);
        end
    end

    // Payload register: load on each transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= in_item;
        end
    end

    mmcs_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s1_fire),
        .i_item   (r_s1_item),
        .i_len    (r_len),
        .o_result (track_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && s1_emits) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_emits) begin
            r_out <= track_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}},
                              r_out.best_score, r_out.best_errors, r_out.best_id};

endmodule

/* rtl/mmcs_track.sv */
module mmcs_track import mmcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  t_item            i_item,
    input  logic [LEN_W-1:0] i_len,
    output t_result          o_result
);

    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [ERR_W-1:0]   r_err,   n_err;
    logic [SCORE_W-1:0] r_wt,    n_wt;
    logic [POS_W-1:0]   r_first, n_first;

    logic               r_have;
    logic [ID_W-1:0]    r_hid,   n_hid;
    logic [ERR_W-1:0]   r_herr,  n_herr;
    logic [SCORE_W-1:0] r_hwt,   n_hwt;
    logic [POS_W-1:0]   r_hfirst, n_hfirst;

    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] wt_idx;
    logic             in_range;
    logic             miss;
    logic             better;

    // Clamp length into 1..MAX_LETTERS.
    always_comb begin
        if (i_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (i_len > LEN_W'(MAX_LETTERS)) begin
            len_eff = LEN_W'(MAX_LETTERS);
        end else begin
            len_eff = i_len;
        end
    end

    assign in_range = r_pos < len_eff;
    assign miss     = in_range && (i_item.cand_letter != i_item.ref_letter);
    assign wt_idx   = len_eff - r_pos;

    always_comb begin
        n_pos   = in_range ? r_pos + POS_W'(1) : r_pos;
        n_err   = r_err + ERR_W'(miss);
        n_wt    = miss ? r_wt + W_TAB[wt_idx] : r_wt;
        n_first = (miss && r_first == '0) ? r_pos + POS_W'(1) : r_first;
    end

    always_comb begin
        priority if (!r_have || n_err < r_herr) begin
            better = 1'b1;
        end else if (n_err > r_herr) begin
            better = 1'b0;
        end else if (n_wt != r_hwt) begin
            better = n_wt > r_hwt;
        end else begin
            better = n_first < r_hfirst;
        end
    end

    always_comb begin
        if (better) begin
            n_hid    = i_item.cand_id;
            n_herr   = n_err;
            n_hwt    = n_wt;
            n_hfirst = n_first;
        end else begin
            n_hid    = r_hid;
            n_herr   = r_herr;
            n_hwt    = r_hwt;
            n_hfirst = r_hfirst;
        end
    end

    assign o_result.best_id     = n_hid;
    assign o_result.best_errors = n_herr;
    assign o_result.best_score  = n_hwt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_err    <= '0;
            r_wt     <= '0;
            r_first  <= '0;
            r_have   <= 1'b0;
            r_hid    <= '0;
            r_herr   <= '0;
            r_hwt    <= '0;
            r_hfirst <= '0;
        end else if (i_fire) begin
            if (i_item.last_letter) begin
                r_pos   <= '0;
                r_err   <= '0;
                r_wt    <= '0;
                r_first <= '0;
                if (i_item.last_cand) begin
                    r_have   <= 1'b0;
                    r_hid    <= '0;
                    r_herr   <= '0;
                    r_hwt    <= '0;
                    r_hfirst <= '0;
                end else begin
                    r_have   <= 1'b1;
                    r_hid    <= n_hid;
                    r_herr   <= n_herr;
                    r_hwt    <= n_hwt;
                    r_hfirst <= n_hfirst;
                end
            end else begin
                r_pos   <= n_pos;
                r_err   <= n_err;
                r_wt    <= n_wt;
                r_first <= n_first;
            end
        end
    end

endmodule

/* rtl/mmcs_checker.sv */
`include "min_mismatch_candidate_select_macros.svh"

module mmcs_checker import mmcs_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic [ERR_W-1:0]   chk_err;
    logic [SCORE_W-1:0] chk_score;

    assign chk_err   = o_m_axis_tdata[OUT_SCORE_LSB-1:OUT_ERR_LSB];
    assign chk_score = o_m_axis_tdata[OUT_BITS-1:OUT_SCORE_LSB];

    `MMCS_ASSERT_NEXT(a_hold_valid, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "result dropped while stalled")
    `MMCS_ASSERT_NEXT(a_hold_data, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata), "result changed while stalled")
    `MMCS_ASSERT_NOW(a_err_range, o_m_axis_tvalid, chk_err <= ERR_W'(MAX_LETTERS), "mismatch count above string length limit")
    `MMCS_ASSERT_NOW(a_zero_score, o_m_axis_tvalid && chk_err == '0, chk_score == '0, "weight sum without mismatches")

endmodule

bind min_mismatch_candidate_select mmcs_checker u_mmcs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

/* tb/min_mismatch_candidate_select_test.sv */
`timescale 1ns / 1ps

module min_mismatch_candidate_select_test;
    import mmcs_pkg::*;

    // Fraction bits of the fine log series, before rounding to the table width
    localparam int FINE_BITS = 56;
    // Cycles to let the scoring pipe empty after the last winner has arrived
    localparam int SETTLE_CYCLES = 8;

    // Candidate shapes for the random part
    typedef enum int {
        SHAPE_EXACT,
        SHAPE_SHORT,
        SHAPE_LONG,
        SHAPE_ID_SWAP,
        SHAPE_STRAY_LAST
    } t_shape;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // [7:0] cand_letter, [15:8] ref_letter, [21:16] cand_id, [23:22] zero
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  i_s_axis_tlast;   // last_letter
    logic [0:0]            i_s_axis_tuser;   // [0] last_cand
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // [5:0] best_id, [12:6] best_errors, [37:13] best_score, [39:38] zero
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_we;
    logic [LEN_W-1:0]      i_cfg_wdata;

    // Predictor state: ln table, length register, running candidate, leader so far
    logic [SCORE_W-1:0] ln_weight [0:MAX_LETTERS];
    logic [LEN_W-1:0]   len_reg;
    logic [POS_W-1:0]   pos_now;
    logic [ERR_W-1:0]   run_errors;
    logic [SCORE_W-1:0] run_weight;
    logic [POS_W-1:0]   run_first_miss;
    logic               lead_valid;
    logic [ID_W-1:0]    lead_id;
    logic [ERR_W-1:0]   lead_errors;
    logic [SCORE_W-1:0] lead_weight;
    logic [POS_W-1:0]   lead_first_miss;

    // Winners still owed by the block, oldest first
    t_result winners_due [$];

    int src_idle     = 0;
    int sink_idle    = 0;
    int hold_off     = 0;
    int letters_sent = 0;
    int winners_seen = 0;
    int failures     = 0;
    int cfg_writes   = 0;
    int input_stalls = 0;

    min_mismatch_candidate_select u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2000000;
        $display("min_mismatch_candidate_select_test: done, errors");
        $finish;
    end

    // 2*atanh(p/q) in fixed point, integer series only
    function automatic longint unsigned atanh_x2(longint unsigned p, longint unsigned q);
        longint unsigned t;
        longint unsigned s;
        longint unsigned j;
        t = (p << FINE_BITS) / q;
        s = 0;
        j = 1;
        while (t != 0) begin
            s += t / j;
            t = (t / (q * q)) * (p * p);
            j += 2;
        end
        return 2 * s;
    endfunction

    // ln(n) = k*ln2 + 2*atanh((n-2^k)/(n+2^k)), then round half up to the table width
    function automatic void fill_ln_weight();
        longint unsigned ln2;
        longint unsigned pw;
        longint unsigned k;
        longint unsigned v;
        ln2 = atanh_x2(1, 3);
        ln_weight[0] = '0;
        for (int n = 1; n <= MAX_LETTERS; n++) begin
            k  = 0;
            pw = 1;
            while (pw * 2 <= n) begin
                pw *= 2;
                k++;
            end
            v = k * ln2 + atanh_x2(n - pw, n + pw);
            ln_weight[n] = SCORE_W'((v + (64'd1 << (FINE_BITS - 1 - WEIGHT_FRAC_BITS)))
                                    >> (FINE_BITS - WEIGHT_FRAC_BITS));
        end
    endfunction

    // Length in force: zero acts as one, anything past the maximum as the maximum
    function automatic int cur_span();
        if (len_reg == 0)
            return 1;
        if (len_reg > MAX_LETTERS)
            return MAX_LETTERS;
        return len_reg;
    endfunction

    // Advance the predictor by one accepted letter; queue a winner at set end
    function automatic void score_letter(input t_item it);
        logic [LEN_W-1:0] span;
        logic             wins;
        t_result          res;
        span = LEN_W'(cur_span());
        // Letters past the string length are dropped and the position holds
        if (pos_now < span) begin
            if (it.cand_letter != it.ref_letter) begin
                run_errors++;
                run_weight += ln_weight[span - pos_now];
                if (run_first_miss == 0)
                    run_first_miss = pos_now + 1;
            end
            pos_now++;
        end
        if (!it.last_letter)
            return;
        // Fewer errors, then larger weight, then earlier first miss; a full tie
        // keeps the earlier candidate
        if (!lead_valid || run_errors < lead_errors)
            wins = 1'b1;
        else if (run_errors > lead_errors)
            wins = 1'b0;
        else if (run_weight != lead_weight)
            wins = run_weight > lead_weight;
        else
            wins = run_first_miss < lead_first_miss;
        if (wins) begin
            lead_valid      = 1'b1;
            lead_id         = it.cand_id;
            lead_errors     = run_errors;
            lead_weight     = run_weight;
            lead_first_miss = run_first_miss;
        end
        pos_now        = '0;
        run_errors     = '0;
        run_weight     = '0;
        run_first_miss = '0;
        // last_cand only counts on the final letter of a candidate
        if (!it.last_cand)
            return;
        res.best_id     = lead_id;
        res.best_errors = lead_errors;
        res.best_score  = lead_weight;
        winners_due.insert(winners_due.size(), res);
        lead_valid      = 1'b0;
        lead_id         = '0;
        lead_errors     = '0;
        lead_weight     = '0;
        lead_first_miss = '0;
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    function automatic t_item mk(input logic [LTR_W-1:0] cand, input logic [LTR_W-1:0] ref_l,
                                 input logic [ID_W-1:0] id, input logic ll, input logic lc);
        t_item it;
        it.cand_letter = cand;
        it.ref_letter  = ref_l;
        it.cand_id     = id;
        it.last_letter = ll;
        it.last_cand   = lc;
        return it;
    endfunction

    // Offer one letter; hold it until the transfer, then advance the predictor
    task automatic send_letter(input t_item it);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < src_idle) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = IN_DATA_W'({it.cand_id, it.ref_letter, it.cand_letter});
        i_s_axis_tlast  = it.last_letter;
        i_s_axis_tuser  = it.last_cand;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        score_letter(it);
        letters_sent++;
    endtask

    // Drop valid, wait for every owed winner, then let the pipe settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (winners_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(posedge i_clk);
        len_reg = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [MAX_LETTERS-1:0] draw_mask(input int density);
        logic [MAX_LETTERS-1:0] m;
        for (int i = 0; i < MAX_LETTERS; i++)
            m[i] = $urandom_range(99, 0) < density;
        return m;
    endfunction

    // Mostly short lengths so sets stay cheap; a few full, zero and oversize ones
    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return LEN_W'($urandom_range(6, 1));
        if (r < 80)
            return LEN_W'($urandom_range(16, 7));
        if (r < 90)
            return LEN_W'($urandom_range(63, 17));
        if (r < 95)
            return LEN_W'(MAX_LETTERS);
        if (r < 98)
            return '0;
        return LEN_W'($urandom_range(127, 65));
    endfunction

    task automatic send_candidate(input logic [ID_W-1:0] id, input logic [MAX_LETTERS-1:0] mask,
                                  input t_shape shape, input logic ends_set);
        int    span;
        int    count;
        logic  miss;
        t_item it;
        span = cur_span();
        case (shape)
            SHAPE_SHORT: count = $urandom_range(span, 1);
            SHAPE_LONG:  count = span + $urandom_range(3, 1);
            default:     count = span;
        endcase
        for (int i = 0; i < count; i++) begin
            // Past the length the mismatch is random: the block must ignore it
            miss           = (i < span) ? mask[i] : 1'($urandom_range(1, 0));
            it.ref_letter  = LTR_W'($urandom_range(255, 0));
            it.cand_letter = miss ? it.ref_letter ^ LTR_W'($urandom_range(255, 1))
                                  : it.ref_letter;
            it.last_letter = (i == count - 1);
            it.cand_id     = (shape == SHAPE_ID_SWAP && !it.last_letter) ?
                             ID_W'($urandom_range(63, 0)) : id;
            if (it.last_letter)
                it.last_cand = ends_set;
            else
                it.last_cand = (shape == SHAPE_STRAY_LAST) ? 1'($urandom_range(1, 0)) : 1'b0;
            send_letter(it);
        end
    endtask

    // One set; candidates often share a mismatch mask so the tie-breaks get exercised
    task automatic send_set(input int max_cands);
        int                     ncand;
        int                     density;
        int                     r;
        logic [MAX_LETTERS-1:0] shared_mask;
        logic [MAX_LETTERS-1:0] mask;
        t_shape                 shape;
        ncand = $urandom_range(max_cands, 1);
        case ($urandom_range(4, 0))
            0:       density = 0;
            1:       density = 10;
            2:       density = 30;
            3:       density = 60;
            default: density = 100;
        endcase
        shared_mask = draw_mask(density);
        for (int c = 0; c < ncand; c++) begin
            mask = ($urandom_range(99, 0) < 40) ? shared_mask : draw_mask(density);
            r    = $urandom_range(99, 0);
            if (r < 85)
                shape = SHAPE_EXACT;
            else if (r < 89)
                shape = SHAPE_SHORT;
            else if (r < 93)
                shape = SHAPE_LONG;
            else if (r < 97)
                shape = SHAPE_ID_SWAP;
            else
                shape = SHAPE_STRAY_LAST;
            send_candidate(ID_W'($urandom_range(63, 0)), mask, shape, c == ncand - 1);
        end
    endtask

    // Reset length applies; a short candidate counts missing letters as matches
    task automatic test_reset_length();
        send_letter(mk(8'h00, 8'hFF, 6'd63, 1'b0, 1'b0));
        send_letter(mk(8'hFF, 8'hFF, 6'd63, 1'b0, 1'b0));
        send_letter(mk(8'hA5, 8'h5A, 6'd63, 1'b1, 1'b1));
        wait_idle();
    endtask

    // Length zero acts as one: overlong letters dropped, stray last_cand ignored,
    // full tie keeps the earlier candidate
    task automatic test_short_length_clamp();
        set_length('0);
        send_letter(mk(8'h3C, 8'h3C, 6'd20, 1'b1, 1'b0));
        send_letter(mk(8'h11, 8'h11, 6'd1, 1'b0, 1'b0));
        send_letter(mk(8'h00, 8'hFF, 6'd1, 1'b0, 1'b1));
        send_letter(mk(8'h80, 8'h7F, 6'd1, 1'b1, 1'b1));
        wait_idle();
    endtask

    // Oversize length acts as the maximum; a new length lands mid-candidate
    task automatic test_length_change_midway();
        set_length(7'h7F);
        send_letter(mk(8'h01, 8'h02, 6'd42, 1'b0, 1'b0));
        send_letter(mk(8'hFE, 8'h01, 6'd42, 1'b0, 1'b0));
        wait_idle();
        set_length(7'd2);
        send_letter(mk(8'h55, 8'hAA, 6'd21, 1'b1, 1'b1));
        wait_idle();
    endtask

    // Same error count, weights ln6+ln1 against ln3+ln2: tie on the rounded
    // table goes to the earlier first miss
    task automatic test_weight_tie();
        set_length(7'd6);
        for (int i = 0; i < 6; i++)
            send_letter(mk((i == 0 || i == 5) ? 8'h41 : 8'h42, 8'h42, 6'd7, i == 5, 1'b0));
        for (int i = 0; i < 6; i++)
            send_letter(mk((i == 3 || i == 4) ? 8'h41 : 8'h42, 8'h42, 6'd8, i == 5, 1'b1));
        wait_idle();
    endtask

    // Random sets under one idling pattern; new length between groups of sets
    task automatic test_random_sets(input int n_items, input int src_pct, input int sink_pct);
        int stop_at;
        int span;
        stop_at   = letters_sent + n_items;
        src_idle  = src_pct;
        sink_idle = sink_pct;
        while (letters_sent < stop_at) begin
            wait_idle();
            set_length(pick_length());
            span = cur_span();
            for (int s = 0; s < ((span > 16) ? 1 : 6) && letters_sent < stop_at; s++)
                send_set((span > 16) ? 2 : 4);
        end
        wait_idle();
    endtask

    // Hold the result side off while short sets keep coming, so the input stalls
    task automatic test_result_backpressure();
        src_idle  = 0;
        sink_idle = 0;
        set_length(7'd2);
        hold_off = 300;
        for (int s = 0; s < 40; s++)
            send_set(1);
        wait_idle();
    endtask

    // Result side: ready pattern per cycle, with an optional long hold-off
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                i_m_axis_tready = 1'b0;
                hold_off--;
            end else begin
                i_m_axis_tready = $urandom_range(99, 0) >= sink_idle;
            end
        end
    end

    // Compare every winner transfer against the oldest owed winner
    always @(posedge i_clk) begin : check_winner
        t_result want;
        t_result got;
        if (i_rst_n && i_s_axis_tvalid && !o_s_axis_tready)
            input_stalls++;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.best_id     = o_m_axis_tdata[ID_W-1:0];
            got.best_errors = o_m_axis_tdata[OUT_ERR_LSB +: ERR_W];
            got.best_score  = o_m_axis_tdata[OUT_SCORE_LSB +: SCORE_W];
            winners_seen++;
            if (winners_due.size() == 0) begin
                failures++;
                $display("%0t: winner with none pending, expected none, actual id %0d errors %0d score %0d",
                         $time, got.best_id, got.best_errors, got.best_score);
            end else begin
                want = winners_due.pop_front();
                check_field("best_id", want.best_id, got.best_id);
                check_field("best_errors", want.best_errors, got.best_errors);
                check_field("best_score", want.best_score, got.best_score);
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        i_s_axis_tuser  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        fill_ln_weight();
        len_reg         = LEN_RESET;
        pos_now         = '0;
        run_errors      = '0;
        run_weight      = '0;
        run_first_miss  = '0;
        lead_valid      = 1'b0;
        lead_id         = '0;
        lead_errors     = '0;
        lead_weight     = '0;
        lead_first_miss = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_length();
        test_short_length_clamp();
        test_length_change_midway();
        test_weight_tie();
        test_random_sets(450, 8, 74);
        test_random_sets(450, 74, 8);
        test_result_backpressure();
        test_random_sets(450, 0, 0);

        wait_idle();
        $display("Run covered %0d letters and %0d winners over %0d length settings,",
                 letters_sent, winners_seen, cfg_writes);
        $display("  with ties, odd-sized candidates and %0d stalled input cycles.", input_stalls);
        if (failures == 0)
            $display("min_mismatch_candidate_select_test: done, clean");
        else
            $display("min_mismatch_candidate_select_test: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mmcs_pkg.sv
rtl/mmcs_track.sv
rtl/min_mismatch_candidate_select.sv
rtl/mmcs_checker.sv
tb/min_mismatch_candidate_select_test.sv
